// File: rtl/wsd_pkg.sv
`timescale 1ns / 1ps

package wsd_pkg;

    localparam int SAMPLE_WIDTH    = 24;
    localparam int EXP_TABLE_DEPTH = 256;

    localparam int GAIN_WIDTH      = 16;
    localparam int GAIN_FRAC       = 12;
    localparam int MODE_WIDTH      = 3;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 16;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SHAPER_MODE = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_INPUT_GAIN  = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OUTPUT_GAIN = 2'd2;

    // Shaper modes.
    localparam logic [MODE_WIDTH-1:0] MODE_HARD = 3'd0;
    localparam logic [MODE_WIDTH-1:0] MODE_SOFT = 3'd1;
    localparam logic [MODE_WIDTH-1:0] MODE_EXP  = 3'd2;
    localparam logic [MODE_WIDTH-1:0] MODE_FULL = 3'd3;
    localparam logic [MODE_WIDTH-1:0] MODE_HALF = 3'd4;

    localparam logic [MODE_WIDTH-1:0] MODE_RESET        = MODE_FULL;
    localparam logic [GAIN_WIDTH-1:0] INPUT_GAIN_RESET  = 16'd16306;
    localparam logic [GAIN_WIDTH-1:0] OUTPUT_GAIN_RESET = 16'd259;

    // Pipeline depths: the shaper core, and the whole path from input to output register.
    localparam int SHAPER_LATENCY = 6;
    localparam int PIPE_LATENCY   = SHAPER_LATENCY + 3;

    localparam int EXP_FRAC_BITS    = 16;
    localparam int EXP_SERIES_TERMS = 24;
    localparam logic [63:0] EXP_M1_Q32 = 64'd1580030170;

    // Entry K of the curve 1 - e^-x over x in [0, 16), sampled at 16K/Depth.
    // The fractional part of x goes through a Taylor series in Q32, and each
    // whole unit multiplies by e^-1. Evaluated at elaboration only.
    function automatic logic [63:0] exp_entry(input int unsigned K,
                                              input int unsigned Depth,
                                              input int unsigned Width);
        logic [63:0] x;
        logic [63:0] n;
        logic [63:0] f;
        logic [63:0] s;
        logic [63:0] t;
        logic [63:0] e;
        x = (64'(K) << 36) / 64'(Depth);
        n = x >> 32;
        f = x & 64'hFFFF_FFFF;
        s = 64'd1 << 32;
        t = 64'd1 << 32;
        for (int unsigned Step = 1; Step <= EXP_SERIES_TERMS; Step++)
        begin
            t = ((t * f) >> 32) / 64'(Step);
            if (Step[0])
            begin
                s = s - t;
            end
            else
            begin
                s = s + t;
            end
        end
        for (int unsigned j = 0; j < 16; j++)
        begin
            if (64'(j) < n)
            begin
                s = (s * EXP_M1_Q32 + (64'd1 << 31)) >> 32;
            end
        end
        e = (s + (64'd1 << (32 - Width))) >> (33 - Width);
        return (64'd1 << (Width - 1)) - e;
    endfunction

endpackage

// File: rtl/waveshaping_distortion.sv
// Waveshaping distortion for a stream of signed Q1.23 audio samples.
//
// Input channel: in_valid, in_stall, sample_in. Output channel: out_valid,
// out_stall, sample_out. A transfer happens on a rising edge where valid is
// high and stall is low. Each sample is multiplied by input_gain, passed
// through the shaper chosen by shaper_mode, multiplied by output_gain and
// saturated to full scale. Samples are independent of each other.
//
// An input transfer passes through these registers in order: the input gain
// multiplier, the shaper stages (soft clip square and divide by three,
// exponential table read and interpolation), the output gain multiplier and
// saturation into the output register. One sample is taken every cycle while
// the pipeline is not held.
//
// When the receiver stalls a waiting result, the whole pipeline holds and
// in_stall is raised in the same cycle; nothing is dropped or repeated.
// Reset clears all valid bits and loads full-wave mode, +12 dB input gain
// and -24 dB output gain. The user must write the configuration registers via
// cfg_we, cfg_index and cfg_wdata only while no sample is in flight; unenforced.
`timescale 1ns / 1ps

module waveshaping_distortion #(
    parameter int SAMPLE_WIDTH    = wsd_pkg::SAMPLE_WIDTH,
    parameter int EXP_TABLE_DEPTH = wsd_pkg::EXP_TABLE_DEPTH
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [wsd_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [wsd_pkg::CFG_DATA_WIDTH-1:0]     cfg_wdata,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]         sample_in,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]         sample_out
);

    localparam int F   = SAMPLE_WIDTH - 1;
    localparam int VW  = SAMPLE_WIDTH + 4;
    localparam int ZW  = VW + wsd_pkg::GAIN_WIDTH + 1 - wsd_pkg::GAIN_FRAC;
    localparam int LAT = wsd_pkg::PIPE_LATENCY;

    localparam logic signed [ZW-1:0] SAT_MAX = ZW'((longint'(1) << F) - 1);
    localparam logic signed [ZW-1:0] SAT_MIN = ZW'(-(longint'(1) << F));

    typedef struct packed {
        logic [wsd_pkg::MODE_WIDTH-1:0] shaper_mode;
        logic [wsd_pkg::GAIN_WIDTH-1:0] input_gain;
        logic [wsd_pkg::GAIN_WIDTH-1:0] output_gain;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        shaper_mode: wsd_pkg::MODE_RESET,
        input_gain:  wsd_pkg::INPUT_GAIN_RESET,
        output_gain: wsd_pkg::OUTPUT_GAIN_RESET
    };

    cfg_t                      cfg_reg;
    logic                      en;
    logic [LAT-1:0]            valid_reg;
    logic signed [VW-1:0]      v1;
    logic signed [VW-1:0]      y7;
    logic signed [ZW-1:0]      z8;
    logic signed [SAMPLE_WIDTH-1:0] sample_out_next;
    logic signed [SAMPLE_WIDTH-1:0] sample_out_reg;

    // Configuration registers. Writes to an index past the last register are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                wsd_pkg::REG_SHAPER_MODE:
                begin
                    cfg_reg.shaper_mode <= cfg_wdata[wsd_pkg::MODE_WIDTH-1:0];
                end
                wsd_pkg::REG_INPUT_GAIN:
                begin
                    cfg_reg.input_gain <= cfg_wdata[wsd_pkg::GAIN_WIDTH-1:0];
                end
                wsd_pkg::REG_OUTPUT_GAIN:
                begin
                    cfg_reg.output_gain <= cfg_wdata[wsd_pkg::GAIN_WIDTH-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // All stages advance together unless a finished result is held by the receiver.
    assign en       = !(valid_reg[LAT-1] && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[LAT-2:0], in_valid};
        end
    end

    wsd_gain #(
        .IN_W  (SAMPLE_WIDTH),
        .OUT_W (VW)
    ) u_gain_in (
        .clk  (clk),
        .en   (en),
        .din  (sample_in),
        .gain (cfg_reg.input_gain),
        .dout (v1)
    );

    wsd_shaper #(
        .SAMPLE_WIDTH    (SAMPLE_WIDTH),
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_shaper (
        .clk  (clk),
        .en   (en),
        .mode (cfg_reg.shaper_mode),
        .v    (v1),
        .y    (y7)
    );

    wsd_gain #(
        .IN_W  (VW),
        .OUT_W (ZW)
    ) u_gain_out (
        .clk  (clk),
        .en   (en),
        .din  (y7),
        .gain (cfg_reg.output_gain),
        .dout (z8)
    );

    // Saturate the post-gain value to the output format.
    always_comb
    begin
        if (z8 > SAT_MAX)
        begin
            sample_out_next = SAT_MAX[SAMPLE_WIDTH-1:0];
        end
        else if (z8 < SAT_MIN)
        begin
            sample_out_next = SAT_MIN[SAMPLE_WIDTH-1:0];
        end
        else
        begin
            sample_out_next = z8[SAMPLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sample_out_reg <= sample_out_next;
        end
    end

    assign out_valid  = valid_reg[LAT-1];
    assign sample_out = sample_out_reg;

endmodule

// File: rtl/wsd_gain.sv
`timescale 1ns / 1ps

// Registered multiply by an unsigned Q4.12 gain, rounding toward minus infinity.
module wsd_gain #(
    parameter int IN_W  = wsd_pkg::SAMPLE_WIDTH,
    parameter int OUT_W = wsd_pkg::SAMPLE_WIDTH + 4
) (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [IN_W-1:0]               din,
    input  logic        [wsd_pkg::GAIN_WIDTH-1:0] gain,
    output logic signed [OUT_W-1:0]              dout
);

    localparam int PW = IN_W + wsd_pkg::GAIN_WIDTH + 1;

    logic signed [PW-1:0]    prod;
    logic signed [PW-1:0]    scaled;
    logic signed [OUT_W-1:0] dout_reg;

    assign prod   = PW'(din) * $signed(PW'({1'b0, gain}));
    assign scaled = prod >>> wsd_pkg::GAIN_FRAC;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout_reg <= scaled[OUT_W-1:0];
        end
    end

    assign dout = dout_reg;

endmodule

// File: rtl/wsd_exp_lut.sv
`timescale 1ns / 1ps

// Constant table of the exponential curve with a registered read. Each entry
// also carries the step to the next entry, so one address serves the interpolation.
module wsd_exp_lut #(
    parameter int SAMPLE_WIDTH    = wsd_pkg::SAMPLE_WIDTH,
    parameter int EXP_TABLE_DEPTH = wsd_pkg::EXP_TABLE_DEPTH
) (
    input  logic                               clk,
    input  logic                               en,
    input  logic [$clog2(EXP_TABLE_DEPTH)-1:0] idx,
    output logic [SAMPLE_WIDTH-1:0]            base,
    output logic [SAMPLE_WIDTH-1:0]            diff
);

    localparam int F = SAMPLE_WIDTH - 1;

    logic [F:0] base_rom [EXP_TABLE_DEPTH];
    logic [F:0] diff_rom [EXP_TABLE_DEPTH];
    logic [F:0] base_reg;
    logic [F:0] diff_reg;

    for (genvar k = 0; k < EXP_TABLE_DEPTH; k++)
    begin : g_rom
        localparam logic [63:0] LO = wsd_pkg::exp_entry(k, EXP_TABLE_DEPTH, SAMPLE_WIDTH);
        localparam logic [63:0] HI = wsd_pkg::exp_entry(k + 1, EXP_TABLE_DEPTH, SAMPLE_WIDTH);
        localparam logic [63:0] DF = (HI >= LO) ? HI - LO : 64'd0;
        assign base_rom[k] = LO[F:0];
        assign diff_rom[k] = DF[F:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            base_reg <= base_rom[idx];
            diff_reg <= diff_rom[idx];
        end
    end

    assign base = base_reg;
    assign diff = diff_reg;

endmodule

// File: rtl/wsd_shaper.sv
`timescale 1ns / 1ps

// Six-stage shaper core. All shapers work on the magnitude of the gained
// sample; the sign is restored in the last stage where the curve is odd.
module wsd_shaper #(
    parameter int SAMPLE_WIDTH    = wsd_pkg::SAMPLE_WIDTH,
    parameter int EXP_TABLE_DEPTH = wsd_pkg::EXP_TABLE_DEPTH
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic [wsd_pkg::MODE_WIDTH-1:0]      mode,
    input  logic signed [SAMPLE_WIDTH+3:0]      v,
    output logic signed [SAMPLE_WIDTH+3:0]      y
);

    localparam int F     = SAMPLE_WIDTH - 1;
    localparam int AW    = SAMPLE_WIDTH + 3;
    localparam int TW    = AW + 2;
    localparam int SW    = 2 * F + 2;
    localparam int MW    = F - 1;
    localparam int FRW   = wsd_pkg::EXP_FRAC_BITS;
    localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);
    localparam int PW    = AW + $clog2(EXP_TABLE_DEPTH + 1);

    localparam logic [TW-1:0]   ONE_T      = TW'(longint'(1) << F);
    localparam logic [TW-1:0]   TWO_ONE_T  = TW'(longint'(2) << F);
    localparam logic [AW-1:0]   HALF_A     = AW'(longint'(1) << (F - 1));
    localparam logic [SW:0]     ROUND_BIAS = (SW + 1)'(longint'(3) << F);
    localparam logic [MW-1:0]   RECIP3     = MW'((longint'(1) << F) / 3);

    // Stage 2: magnitude, soft clip region, exponential address.
    logic            neg2_next;
    logic [AW-1:0]   a2_next;
    logic [TW-1:0]   three_a;
    logic [PW-1:0]   p2;
    logic            neg2_reg;
    logic [AW-1:0]   a2_reg;
    logic            sat2_reg;
    logic            quad2_reg;
    logic [F:0]      d2_reg;
    logic [IDX_W-1:0] idx2_reg;
    logic [FRW-1:0]  fr2_reg;

    // Stage 3: square of the soft clip distance, table read.
    logic            neg3_reg;
    logic [AW-1:0]   a3_reg;
    logic            sat3_reg;
    logic            quad3_reg;
    logic [SW-1:0]   dsq3_reg;
    logic [FRW-1:0]  fr3_reg;
    logic [F:0]      base3;
    logic [F:0]      diff3;

    // Stage 4: scaled square, interpolation product.
    logic [SW:0]      bias_sum;
    logic             neg4_reg;
    logic [AW-1:0]    a4_reg;
    logic             sat4_reg;
    logic             quad4_reg;
    logic [F-1:0]     q0_4_reg;
    logic [F+FRW:0]   eprod4_reg;
    logic [F:0]       base4_reg;

    // Stage 5: reciprocal multiply for the divide by three, interpolation sum.
    logic             neg5_reg;
    logic [AW-1:0]    a5_reg;
    logic             sat5_reg;
    logic             quad5_reg;
    logic [F-1:0]     q0_5_reg;
    logic [F+MW-1:0]  qm5_reg;
    logic [F:0]       emag5_reg;

    // Stage 6: quotient correction.
    logic [F-1:0]     qe6;
    logic [2:0]       rem6;
    logic [F-1:0]     q6_next;
    logic             neg6_reg;
    logic [AW-1:0]    a6_reg;
    logic             sat6_reg;
    logic             quad6_reg;
    logic [F-1:0]     q6_reg;
    logic [F:0]       emag6_reg;

    // Stage 7: mode select and sign.
    logic [AW-1:0]    mag7;
    logic             odd7;
    logic signed [AW:0] y7_next;
    logic signed [AW:0] y7_reg;

    assign neg2_next = v[AW];
    assign a2_next   = neg2_next ? AW'(-v) : AW'(v);
    assign three_a   = (TW'(a2_next) << 1) + TW'(a2_next);
    assign p2        = PW'(a2_next) * PW'(EXP_TABLE_DEPTH);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg2_reg  <= neg2_next;
            a2_reg    <= a2_next;
            sat2_reg  <= three_a > TWO_ONE_T;
            quad2_reg <= three_a > ONE_T;
            d2_reg    <= (F + 1)'(TWO_ONE_T - three_a);
            idx2_reg  <= IDX_W'(p2 >> (F + 4));
            fr2_reg   <= p2[F+3 -: FRW];
        end
    end

    wsd_exp_lut #(
        .SAMPLE_WIDTH    (SAMPLE_WIDTH),
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_exp_lut (
        .clk  (clk),
        .en   (en),
        .idx  (idx2_reg),
        .base (base3),
        .diff (diff3)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg3_reg  <= neg2_reg;
            a3_reg    <= a2_reg;
            sat3_reg  <= sat2_reg;
            quad3_reg <= quad2_reg;
            dsq3_reg  <= SW'(d2_reg) * SW'(d2_reg);
            fr3_reg   <= fr2_reg;
        end
    end

    // floor((d*d + 3*ONE) / (6*ONE)) is split into a shift by 2*ONE and a divide by three.
    assign bias_sum = (SW + 1)'(dsq3_reg) + ROUND_BIAS;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg4_reg   <= neg3_reg;
            a4_reg     <= a3_reg;
            sat4_reg   <= sat3_reg;
            quad4_reg  <= quad3_reg;
            q0_4_reg   <= F'(bias_sum >> (F + 1));
            eprod4_reg <= (F + FRW + 1)'(diff3) * (F + FRW + 1)'(fr3_reg);
            base4_reg  <= base3;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg5_reg  <= neg4_reg;
            a5_reg    <= a4_reg;
            sat5_reg  <= sat4_reg;
            quad5_reg <= quad4_reg;
            q0_5_reg  <= q0_4_reg;
            qm5_reg   <= (F + MW)'(q0_4_reg) * (F + MW)'(RECIP3);
            emag5_reg <= base4_reg + (F + 1)'(eprod4_reg >> FRW);
        end
    end

    // The reciprocal estimate is low by at most one, so the remainder stays below six.
    assign qe6     = F'(qm5_reg >> F);
    assign rem6    = 3'(q0_5_reg - (qe6 + (qe6 << 1)));
    assign q6_next = qe6 + F'(rem6 >= 3'd3);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg6_reg  <= neg5_reg;
            a6_reg    <= a5_reg;
            sat6_reg  <= sat5_reg;
            quad6_reg <= quad5_reg;
            q6_reg    <= q6_next;
            emag6_reg <= emag5_reg;
        end
    end

    always_comb
    begin
        mag7 = '0;
        odd7 = 1'b0;
        case (mode)
            wsd_pkg::MODE_HARD:
            begin
                mag7 = (a6_reg > HALF_A) ? HALF_A : a6_reg;
                odd7 = 1'b1;
            end
            wsd_pkg::MODE_SOFT:
            begin
                if (sat6_reg)
                begin
                    mag7 = HALF_A;
                end
                else if (quad6_reg)
                begin
                    mag7 = HALF_A - AW'(q6_reg);
                end
                else
                begin
                    mag7 = a6_reg;
                end
                odd7 = 1'b1;
            end
            wsd_pkg::MODE_EXP:
            begin
                mag7 = AW'(emag6_reg);
                odd7 = 1'b1;
            end
            wsd_pkg::MODE_FULL:
            begin
                mag7 = a6_reg;
            end
            wsd_pkg::MODE_HALF:
            begin
                mag7 = neg6_reg ? '0 : a6_reg;
            end
            default:
            begin
                mag7 = '0;
            end
        endcase
    end

    assign y7_next = (odd7 && neg6_reg) ? -$signed({1'b0, mag7}) : $signed({1'b0, mag7});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y7_reg <= y7_next;
        end
    end

    assign y = y7_reg;

endmodule

// File: rtl/wsd_checker.sv
`timescale 1ns / 1ps

module wsd_checker #(
    parameter int SAMPLE_WIDTH = wsd_pkg::SAMPLE_WIDTH
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_stall,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic [SAMPLE_WIDTH-1:0] sample_out
);

    localparam int LAT   = wsd_pkg::PIPE_LATENCY;
    localparam int CNT_W = $clog2(LAT + 1);

    // Counts consecutive cycles with no result shown, during which the pipeline never holds.
    logic [CNT_W-1:0] quiet_cnt_reg;
    logic [CNT_W-1:0] quiet_cnt_next;

    assign quiet_cnt_next = out_valid ? '0 :
                            (quiet_cnt_reg == CNT_W'(LAT)) ? quiet_cnt_reg :
                            quiet_cnt_reg + CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_cnt_reg <= '0;
        end
        else
        begin
            quiet_cnt_reg <= quiet_cnt_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample_out))
        else $error("result changed or vanished while stalled");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a held result");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        quiet_cnt_reg == CNT_W'(LAT) |-> out_valid == $past(in_valid, LAT))
        else $error("result does not follow its input by the pipeline latency");

endmodule

bind waveshaping_distortion wsd_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_wsd_checker (.*);

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;

    // Sample format and curve geometry, taken from the package so that the
    // predictor follows the block's configuration.
    localparam int SW        = wsd_pkg::SAMPLE_WIDTH;
    localparam int FB        = SW - 1;
    localparam int DEPTH     = wsd_pkg::EXP_TABLE_DEPTH;
    localparam int DOM       = FB + 4;
    localparam longint ONE   = longint'(1) << FB;
    localparam longint MAX_SAMPLE = ONE - 1;
    localparam longint MIN_SAMPLE = -ONE;

    // An index that maps to no register; a write to it must change nothing.
    localparam logic [wsd_pkg::CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;

    localparam longint unsigned E_INV_Q32 = 64'd1580030170;
    localparam int IDLE_PERCENT = 18;
    localparam int HOLD_CYCLES  = 120;
    localparam int CYCLE_LIMIT  = 300000;

    typedef struct {
        logic signed [SW-1:0] sample;
        logic signed [SW-1:0] shaped;
    } shaped_sample_t;

    logic                                 clk       = 1'b0;
    logic                                 rst_n     = 1'b0;
    logic                                 cfg_we    = 1'b0;
    logic [wsd_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index = '0;
    logic [wsd_pkg::CFG_DATA_WIDTH-1:0]   cfg_wdata = '0;
    logic                                 in_valid  = 1'b0;
    logic                                 in_stall;
    logic signed [SW-1:0]                 sample_in = '0;
    logic                                 out_valid;
    logic                                 out_stall = 1'b0;
    logic signed [SW-1:0]                 sample_out;

    // Shadow copy of the configuration registers, loaded with the reset values.
    logic [wsd_pkg::MODE_WIDTH-1:0] mode_q     = wsd_pkg::MODE_RESET;
    logic [wsd_pkg::GAIN_WIDTH-1:0] in_gain_q  = wsd_pkg::INPUT_GAIN_RESET;
    logic [wsd_pkg::GAIN_WIDTH-1:0] out_gain_q = wsd_pkg::OUTPUT_GAIN_RESET;

    // Samples of the curve 1 - e^-x, filled once before any traffic.
    longint unsigned curve [0:DEPTH];

    shaped_sample_t awaited_samples [$];
    shaped_sample_t oldest;
    int mismatches = 0;
    int cycles = 0;

    // Random idling on both channels is switched off for the no-idle stretch.
    bit idling_on = 1'b1;

    // The main flow asks for a long receiver hold-off by bumping hold_requests;
    // the stall process notices the change and counts the stretch itself.
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    waveshaping_distortion uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out)
    );

    always #5 clk = ~clk;

    // One point of the exponential curve. The fractional part of 16k/DEPTH
    // goes through an alternating Taylor series in Q32; each whole unit then
    // multiplies by e^-1 with rounding. The result is rounded to the sample
    // format and subtracted from one.
    function automatic longint unsigned curve_point(input int k);
        longint unsigned pos;
        longint unsigned whole;
        longint unsigned part;
        longint unsigned acc;
        longint unsigned term;
        longint unsigned decay;
        pos   = (64'(k) << 36) / 64'(DEPTH);
        whole = pos >> 32;
        part  = pos & 64'hFFFF_FFFF;
        acc   = 64'd1 << 32;
        term  = 64'd1 << 32;
        for (int i = 1; i <= 24; i++)
        begin
            term = ((term * part) >> 32) / 64'(i);
            if (i % 2 == 1)
            begin
                acc = acc - term;
            end
            else
            begin
                acc = acc + term;
            end
        end
        for (longint unsigned j = 0; j < whole; j++)
        begin
            acc = (acc * E_INV_Q32 + (64'd1 << 31)) >> 32;
        end
        decay = (acc + (64'd1 << (32 - SW))) >> (33 - SW);
        return longint'(ONE) - decay;
    endfunction

    // Piecewise-quadratic soft clip on a magnitude: linear up to one third,
    // a parabola up to two thirds, then flat at one half.
    function automatic longint soft_knee(input longint mag);
        longint span;
        if (3 * mag > 2 * ONE)
        begin
            return ONE / 2;
        end
        if (3 * mag > ONE)
        begin
            span = 2 * ONE - 3 * mag;
            return ONE / 2 - (span * span + 3 * ONE) / (6 * ONE);
        end
        return mag;
    endfunction

    // Table lookup with linear interpolation on a 16-bit fraction. Beyond the
    // last segment the top entry is used as is.
    function automatic longint exp_curve(input longint mag);
        longint unsigned pos;
        longint unsigned seg;
        longint unsigned frac;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned rise;
        pos = longint'(mag) * DEPTH;
        seg = pos >> DOM;
        if (seg >= DEPTH)
        begin
            return longint'(curve[DEPTH]);
        end
        frac = (pos & ((64'd1 << DOM) - 1)) >> (DOM - 16);
        lo   = curve[seg];
        hi   = curve[seg + 1];
        rise = (hi >= lo) ? hi - lo : 0;
        return longint'(lo + ((rise * frac) >> 16));
    endfunction

    // Expected output for one input sample under the current shadow registers.
    function automatic logic signed [SW-1:0] predict_shaped(input logic signed [SW-1:0] value);
        longint gained;
        longint mag;
        longint shaped;
        longint scaled;
        gained = (longint'(value) * longint'(in_gain_q)) >>> wsd_pkg::GAIN_FRAC;
        mag    = (gained < 0) ? -gained : gained;
        case (mode_q)
            wsd_pkg::MODE_HARD:
            begin
                if (gained > ONE / 2)
                begin
                    shaped = ONE / 2;
                end
                else if (gained < -(ONE / 2))
                begin
                    shaped = -(ONE / 2);
                end
                else
                begin
                    shaped = gained;
                end
            end
            wsd_pkg::MODE_SOFT: shaped = (gained < 0) ? -soft_knee(mag) : soft_knee(mag);
            wsd_pkg::MODE_EXP:  shaped = (gained < 0) ? -exp_curve(mag) : exp_curve(mag);
            wsd_pkg::MODE_FULL: shaped = mag;
            wsd_pkg::MODE_HALF: shaped = (gained > 0) ? gained : 0;
            default:            shaped = 0;
        endcase
        scaled = (shaped * longint'(out_gain_q)) >>> wsd_pkg::GAIN_FRAC;
        if (scaled > MAX_SAMPLE)
        begin
            scaled = MAX_SAMPLE;
        end
        if (scaled < MIN_SAMPLE)
        begin
            scaled = MIN_SAMPLE;
        end
        return scaled[SW-1:0];
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Offers one sample on the input channel and waits for its transfer. The
    // valid stays high on return, so back-to-back calls keep the stream dense;
    // it only drops for random idle cycles or when the caller drains.
    task automatic send_sample(input logic signed [SW-1:0] value);
        while (idling_on && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            in_valid  <= 1'b0;
            sample_in <= SW'($urandom);
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        sample_in <= value;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        awaited_samples.push_back('{value, predict_shaped(value)});
    endtask

    // Ends the stream and waits until every transfer has produced its result,
    // so that the registers can be rewritten with nothing in flight.
    task automatic drain();
        in_valid <= 1'b0;
        while (awaited_samples.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // A register write takes one edge with the enable high; the enable is then
    // lowered before the task returns, so that consecutive writes never touch it
    // twice in one time step.
    task automatic write_reg(input logic [wsd_pkg::CFG_INDEX_WIDTH-1:0] index,
                             input logic [wsd_pkg::CFG_DATA_WIDTH-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (index)
            wsd_pkg::REG_SHAPER_MODE: mode_q     = data[wsd_pkg::MODE_WIDTH-1:0];
            wsd_pkg::REG_INPUT_GAIN:  in_gain_q  = data[wsd_pkg::GAIN_WIDTH-1:0];
            wsd_pkg::REG_OUTPUT_GAIN: out_gain_q = data[wsd_pkg::GAIN_WIDTH-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // The mode register is only three bits wide; the bits above it carry
    // random junk that the block has to ignore.
    task automatic write_mode(input logic [wsd_pkg::MODE_WIDTH-1:0] mode);
        logic [wsd_pkg::CFG_DATA_WIDTH-1:0] data;
        data = wsd_pkg::CFG_DATA_WIDTH'($urandom);
        data[wsd_pkg::MODE_WIDTH-1:0] = mode;
        write_reg(wsd_pkg::REG_SHAPER_MODE, data);
    endtask

    function automatic logic [wsd_pkg::CFG_DATA_WIDTH-1:0] random_gain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return {wsd_pkg::GAIN_WIDTH{1'b1}};
            2:       return wsd_pkg::CFG_DATA_WIDTH'(1 << wsd_pkg::GAIN_FRAC);
            3:       return wsd_pkg::CFG_DATA_WIDTH'($urandom_range(0,
                                                     2 << wsd_pkg::GAIN_FRAC));
            default: return wsd_pkg::CFG_DATA_WIDTH'($urandom);
        endcase
    endfunction

    // Mostly the five working shapers, now and then one of the unused codes.
    task automatic configure_random();
        if ($urandom_range(0, 9) > 7)
        begin
            write_mode(wsd_pkg::MODE_WIDTH'($urandom_range(wsd_pkg::MODE_HALF + 1,
                                                           (1 << wsd_pkg::MODE_WIDTH) - 1)));
        end
        else
        begin
            write_mode(wsd_pkg::MODE_WIDTH'($urandom_range(wsd_pkg::MODE_HARD,
                                                           wsd_pkg::MODE_HALF)));
        end
        write_reg(wsd_pkg::REG_INPUT_GAIN, random_gain());
        write_reg(wsd_pkg::REG_OUTPUT_GAIN, random_gain());
    endtask

    // Full-range values most of the time, with small magnitudes to reach the
    // linear parts of the shapers and the corners of the range now and then.
    function automatic logic signed [SW-1:0] random_sample();
        logic signed [SW-1:0] value;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            case ($urandom_range(0, 3))
                0:       value = SW'(MIN_SAMPLE);
                1:       value = SW'(MAX_SAMPLE);
                2:       value = '0;
                default: value = '1;
            endcase
        end
        else if (pick < 3)
        begin
            value = SW'($urandom_range(0, 1 << 16));
            if ($urandom_range(0, 1) == 1)
            begin
                value = -value;
            end
        end
        else
        begin
            value = SW'($urandom);
        end
        return value;
    endfunction

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_sample(random_sample());
        end
    endtask

    // A couple of samples straight out of reset: full-wave mode with the
    // default +12 dB in and -24 dB out.
    task automatic test_reset_defaults();
        send_sample(SW'(MAX_SAMPLE));
        send_sample(SW'(MIN_SAMPLE));
        drain();
    endtask

    // Every mode code, the unused ones included, at unity gains. Negative full
    // scale lands in the flat part of the soft clip; plus one half lands in
    // its quadratic part and exactly on the hard clip limit.
    task automatic test_every_mode();
        write_reg(wsd_pkg::REG_INPUT_GAIN, wsd_pkg::CFG_DATA_WIDTH'(1 << wsd_pkg::GAIN_FRAC));
        write_reg(wsd_pkg::REG_OUTPUT_GAIN, wsd_pkg::CFG_DATA_WIDTH'(1 << wsd_pkg::GAIN_FRAC));
        for (int m = 0; m < (1 << wsd_pkg::MODE_WIDTH); m++)
        begin
            write_mode(wsd_pkg::MODE_WIDTH'(m));
            send_sample(SW'(MIN_SAMPLE));
            send_sample(SW'(ONE / 2));
            drain();
        end
    endtask

    // Largest gains on the exponential curve: full scale reaches the last
    // table segment and the output saturates at both rails. A write to the unused
    // index must leave all of this in place.
    task automatic test_gain_extremes();
        write_mode(wsd_pkg::MODE_EXP);
        write_reg(wsd_pkg::REG_INPUT_GAIN, {wsd_pkg::GAIN_WIDTH{1'b1}});
        write_reg(wsd_pkg::REG_OUTPUT_GAIN, {wsd_pkg::GAIN_WIDTH{1'b1}});
        send_sample(SW'(MAX_SAMPLE));
        send_sample(SW'(MIN_SAMPLE));
        send_sample(SW'(1));
        drain();
        write_reg(REG_UNUSED, '0);
        send_sample(SW'(MAX_SAMPLE));
        drain();
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 10; phase++)
        begin
            configure_random();
            send_random(100);
            drain();
        end
    endtask

    // A long stretch with both channels running flat out.
    task automatic test_no_idle();
        idling_on = 1'b0;
        configure_random();
        send_random(300);
        drain();
        idling_on = 1'b1;
    endtask

    // The receiver holds off long enough for the pipeline to fill while the
    // sender keeps offering, so the input stall has to come up and hold.
    task automatic test_backpressure();
        configure_random();
        hold_requests++;
        send_random(100);
        hold_requests++;
        send_random(100);
        drain();
    endtask

    // Receiver side: random stalls, or a counted hold-off when one is asked for.
    always @(posedge clk)
    begin
        if (hold_requests != hold_served)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            out_stall <= idling_on && ($urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    // Every output transfer is matched against the oldest awaited result.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_samples.size() == 0)
            begin
                report_mismatch("sample_out with no result awaited", sample_out, 0);
            end
            else
            begin
                oldest = awaited_samples.pop_front();
                if (sample_out !== oldest.shaped)
                begin
                    report_mismatch($sformatf("sample_out for input %0d", oldest.sample),
                                    sample_out, oldest.shaped);
                end
            end
        end
    end

    // Watchdog: a run that hangs on a handshake ends here.
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("waveshaping_distortion: mismatch");
        $finish;
    end

    initial
    begin
        for (int k = 0; k <= DEPTH; k++)
        begin
            curve[k] = curve_point(k);
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_every_mode();
        test_gain_extremes();
        test_random_settings();
        test_no_idle();
        test_backpressure();

        // Let the pipeline run empty to catch any result nobody asked for.
        repeat (4 * wsd_pkg::PIPE_LATENCY) @(posedge clk);
        if (awaited_samples.size() != 0)
        begin
            report_mismatch("results still awaited at the end", 0, awaited_samples.size());
        end
        if (mismatches == 0)
        begin
            $display("waveshaping_distortion: match");
        end
        else
        begin
            $display("waveshaping_distortion: mismatch");
        end
        $finish;
    end

endmodule
